// File: rtl/motmr_pkg.sv
`default_nettype none
package motmr_pkg;

	localparam int unsigned SLOTS_DEF      = 32;
	localparam int unsigned EVENT_BITS_DEF = 32;
	localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
	localparam logic [31:0] MIN_LOAD       = 32'd2;

	typedef enum logic [2:0] {
		FN_START   = 3'd0,
		FN_STOP    = 3'd1,
		FN_RESET   = 3'd2,
		FN_EXPIRE  = 3'd3,
		FN_SERVICE = 3'd4,
		FN_QUERY   = 3'd5
	} func_t;

	// operation broadcast to every cell in a sweep
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_SUB,      // saturating subtract of sub_val (for cells below lim)
		OP_EXPIRE,   // subtract current load from nonzero entries
		OP_REMOVE,   // cells at or past pos take their right neighbor
		OP_APPEND,   // cell at pos takes the new entry
		OP_FLOOR     // cell at pos raised to at least the minimum load
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [31:0] sub_val;
		logic [5:0]  lim;       // active cells are those below lim
		logic [5:0]  pos;       // cell position for remove, append, floor
		logic [31:0] new_tmo;
		logic [4:0]  new_ev;
	} cell_ctl_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [4:0]  event_index;
		logic [31:0] timeout_ms;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic        status;
		logic        load_valid;
		logic [31:0] load_value;
		logic [4:0]  fired_index;
		logic        last;
		logic        is_active;
		logic        clear_timeout_event;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_STOP_FIND, ST_STOP_SUB, ST_STOP_RM,
		ST_START_CHK, ST_START_FIND, ST_START_APP, ST_START_SUB,
		ST_EXP_SUB,
		ST_RL_SCAN, ST_RL_FLOOR,
		ST_SVC_BIT, ST_SVC_FIND, ST_SVC_RM,
		ST_QRY_FIND,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

// File: rtl/multiplexed_oneshot_timer_table.sv
// timer table that shares one one-shot hardware timer among up to SLOTS events
// in: one command transaction (start, stop, reset, expire, service, query)
// out: result transactions; one per command, service gives one per fired
//      event with last on the final one
// the table is a row of cells; a subtract, expire or compaction acts on all cells
// at once, while lookups and the minimum search walk the row one entry
// per cycle through a scan counter
// service: an entry result goes out when the next fired entry is found,
// the final one last
// one command at a time: in_stall is high from acceptance until the final
// result transaction is loaded into the output register
// a stalled result holds in the output register until out_stall drops; the
// block waits for a free output register before loading the next result
// reset clears the count and fired mask and sets the load to all ones; table contents need no clear
module multiplexed_oneshot_timer_table #(
	parameter int unsigned SLOTS      = motmr_pkg::SLOTS_DEF,
	parameter int unsigned EVENT_BITS = motmr_pkg::EVENT_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire motmr_pkg::in_item_t  in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output motmr_pkg::out_item_t      out_data
);
	import motmr_pkg::*;

	localparam int unsigned SW = 6;
	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	state_t      state_q, state_d;
	in_item_t    cmd_q;
	logic [SW-1:0] count_q;
	logic [31:0] fired_q;
	logic [31:0] load_q;
	logic [31:0] llt_q;
	logic [SW-1:0] scan_q;     // walking index
	logic [SW-1:0] pos_q;      // found position
	logic        found_q;
	logic [31:0] best_q;
	logic [SW-1:0] bidx_q;
	logic        anyact_q;     // an unfired entry was seen in the scan
	logic        lv_q, clr_q, st_q;
	logic        svc_n_q;      // service has a result held back
	logic [4:0]  svc_pend_q;   // event bit of the held service result
	logic [4:0]  bit_q;
	logic        ret_start_q;  // reload returns to start (reset's second half)
	logic        rl_ok_q;      // reload only if an unfired entry exists

	cell_ctl_t   ctl;
	logic [31:0] tmo [SLOTS];
	logic [4:0]  evs [SLOTS];
	logic [SLOTS-1:0] hz;

	// chain of cells, each taking its right neighbor on compaction
	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		logic [31:0] rt;
		logic [4:0]  re;
		if (g == SLOTS - 1) begin : g_end
			assign rt = '0;
			assign re = '0;
		end else begin : g_mid
			assign rt = tmo[g+1];
			assign re = evs[g+1];
		end
		motmr_cell u_cell (
			.clk(clk), .idx(SW'(g)), .ctl(ctl), .right_tmo(rt), .right_ev(re),
			.cur_load(load_q), .tmo_q(tmo[g]), .ev_q(evs[g]), .hit_zero(hz[g])
		);
	end

	logic [31:0] elapsed;
	logic [31:0] set_fired;
	logic        scan_in;
	logic [31:0] scan_tmo;
	logic [4:0]  scan_ev;
	logic        scan_fired;
	logic        ev_ok;

	assign elapsed = (cmd_q.now_ms > llt_q) ? cmd_q.now_ms - llt_q : llt_q - cmd_q.now_ms;
	assign scan_in = scan_q < count_q;
	assign scan_tmo = tmo[scan_q[IW-1:0]];
	assign scan_ev  = evs[scan_q[IW-1:0]];
	assign scan_fired = fired_q[scan_ev];
	assign ev_ok = 32'(cmd_q.event_index) < EVENT_BITS;

	always_comb begin
		set_fired = '0;
		for (int k = 0; k < SLOTS; k++)
			if (hz[k]) set_fired[evs[k]] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic out_free;
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		state_d = state_q;
		ctl = '{op: OP_HOLD, sub_val: elapsed, lim: count_q, pos: pos_q,
			new_tmo: cmd_q.timeout_ms, new_ev: cmd_q.event_index};
		unique case (state_q)
			ST_STOP_SUB: ctl.op = OP_SUB;
			ST_STOP_RM, ST_SVC_RM: ctl.op = OP_REMOVE;
			ST_START_APP: begin
				ctl.op  = OP_APPEND;
				ctl.pos = count_q;
			end
			ST_START_SUB: begin
				ctl.op  = OP_SUB;
				ctl.lim = count_q - SW'(1);
			end
			ST_EXP_SUB: ctl.op = OP_EXPIRE;
			ST_RL_FLOOR: begin
				ctl.op  = OP_FLOOR;
				ctl.pos = bidx_q;
			end
			default: ;
		endcase
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				unique case (in_data.func)
					FN_START: state_d = ST_START_CHK;
					FN_STOP, FN_RESET: state_d = ST_STOP_FIND;
					FN_EXPIRE: state_d = ST_EXP_SUB;
					FN_SERVICE: state_d = ST_SVC_BIT;
					FN_QUERY: state_d = ST_QRY_FIND;
					default: state_d = ST_EMIT;
				endcase
			end
			ST_STOP_FIND: begin
				if (!ev_ok) state_d = cmd_q.func == FN_RESET ? ST_START_CHK : ST_EMIT;
				else if (scan_in && scan_ev == cmd_q.event_index) state_d = ST_STOP_SUB;
				else if (!scan_in)
					state_d = cmd_q.func == FN_RESET ? ST_START_CHK : ST_EMIT;
			end
			ST_STOP_SUB: state_d = ST_STOP_RM;
			ST_STOP_RM: state_d = ST_RL_SCAN;
			ST_START_CHK: state_d = (!ev_ok || cmd_q.timeout_ms == '0) ? ST_EMIT
				: ST_START_FIND;
			ST_START_FIND: begin
				if (scan_in && scan_ev == cmd_q.event_index) state_d = ST_RL_SCAN;
				else if (!scan_in)
					state_d = (count_q >= SW'(SLOTS)) ? ST_EMIT : ST_START_APP;
			end
			ST_START_APP: state_d = (count_q != '0) ? ST_START_SUB : ST_RL_SCAN;
			ST_START_SUB: state_d = ST_RL_SCAN;
			ST_EXP_SUB: state_d = ST_RL_SCAN;
			// nothing left active: reset still goes on to its start half
			ST_RL_SCAN: if (!scan_in)
				state_d = (rl_ok_q && !anyact_q) ? (ret_start_q ? ST_START_CHK : ST_EMIT)
					: ST_RL_FLOOR;
			ST_RL_FLOOR: state_d = ret_start_q ? ST_START_CHK : ST_EMIT;
			ST_SVC_BIT: begin
				if (fired_q[bit_q]) state_d = ST_SVC_FIND;
				else if (32'(bit_q) == EVENT_BITS - 1) state_d = ST_EMIT;
			end
			ST_SVC_FIND: begin
				if (scan_in && scan_ev == bit_q) begin
					if (out_free) state_d = ST_SVC_RM;
				end else if (!scan_in)
					state_d = (32'(bit_q) == EVENT_BITS - 1) ? ST_EMIT : ST_SVC_BIT;
			end
			ST_SVC_RM: state_d = (32'(bit_q) == EVENT_BITS - 1) ? ST_EMIT : ST_SVC_BIT;
			ST_QRY_FIND: if (!scan_in || (ev_ok && scan_ev == cmd_q.event_index))
				state_d = ST_EMIT;
			ST_EMIT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall = state_q != ST_IDLE;

	// result loading: a held service result goes out once the next fired entry
	// is found (not last), the final transaction at the end of the command
	logic      emit;
	logic      svc_fin;
	out_item_t emit_data;

	assign svc_fin = cmd_q.func == FN_SERVICE && svc_n_q;

	always_comb begin
		emit = 1'b0;
		emit_data = '{status: st_q && !svc_fin, load_valid: lv_q, load_value: load_q,
			fired_index: svc_fin ? svc_pend_q : 5'd0, last: 1'b1, is_active: found_q,
			clear_timeout_event: clr_q};
		if (state_q == ST_SVC_RM) begin
			emit = svc_n_q;
			emit_data.last = 1'b0;
		end else if (state_q == ST_EMIT) begin
			emit = out_free;
		end
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= '0;
			count_q   <= '0;
			fired_q   <= '0;
			load_q    <= ALL_ONES;
			llt_q     <= '0;
			out_valid <= 1'b0;
			out_data  <= '0;
			scan_q    <= '0;
			pos_q     <= '0;
			best_q    <= ALL_ONES;
			bidx_q    <= '0;
			bit_q     <= '0;
			svc_pend_q <= '0;
			lv_q <= 1'b0; clr_q <= 1'b0; st_q <= 1'b0; svc_n_q <= 1'b0;
			found_q <= 1'b0; ret_start_q <= 1'b0; rl_ok_q <= 1'b0;
			anyact_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid <= 1'b1;
				out_data  <= emit_data;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					cmd_q <= in_data;
					scan_q <= '0; bit_q <= '0;
					lv_q <= 1'b0; clr_q <= 1'b0; svc_n_q <= 1'b0;
					found_q <= 1'b0; ret_start_q <= 1'b0;
					st_q <= !(in_data.func == FN_START || in_data.func == FN_STOP
						|| in_data.func == FN_RESET || in_data.func == FN_EXPIRE
						|| in_data.func == FN_QUERY);
				end
				ST_STOP_FIND: begin
					if (ev_ok && scan_in && scan_ev == cmd_q.event_index) pos_q <= scan_q;
					else if (ev_ok && scan_in) scan_q <= scan_q + SW'(1);
					else begin
						st_q <= 1'b1;
						scan_q <= '0;
					end
				end
				ST_STOP_SUB: ;
				ST_STOP_RM: begin
					count_q <= count_q - SW'(1);
					clr_q <= 1'b1; st_q <= 1'b0;
					scan_q <= '0; best_q <= ALL_ONES; bidx_q <= '0;
					anyact_q <= 1'b0; rl_ok_q <= 1'b1;
					ret_start_q <= cmd_q.func == FN_RESET;
				end
				ST_START_CHK: begin
					scan_q <= '0;
					st_q <= !ev_ok || cmd_q.timeout_ms == '0;
				end
				ST_START_FIND: begin
					if (scan_in && scan_ev == cmd_q.event_index) begin
						scan_q <= '0; best_q <= ALL_ONES; bidx_q <= '0;
						rl_ok_q <= 1'b0; ret_start_q <= 1'b0; st_q <= 1'b0;
					end else if (scan_in) scan_q <= scan_q + SW'(1);
					else if (count_q >= SW'(SLOTS)) st_q <= 1'b1;
				end
				ST_START_APP: begin
					count_q <= count_q + SW'(1);
					st_q <= 1'b0;
					scan_q <= '0; best_q <= ALL_ONES; bidx_q <= '0;
					rl_ok_q <= 1'b0; ret_start_q <= 1'b0;
				end
				ST_START_SUB: ;
				ST_EXP_SUB: begin
					fired_q <= fired_q | set_fired;
					scan_q <= '0; best_q <= ALL_ONES; bidx_q <= '0;
					anyact_q <= 1'b0; rl_ok_q <= 1'b1; ret_start_q <= 1'b0;
				end
				ST_RL_SCAN: begin
					if (scan_in) begin
						if (!scan_fired) anyact_q <= 1'b1;
						if (!scan_fired && scan_tmo < best_q) begin
							best_q <= scan_tmo;
							bidx_q <= scan_q;
						end
						scan_q <= scan_q + SW'(1);
					end else if (rl_ok_q && !anyact_q) load_q <= ALL_ONES;
				end
				ST_RL_FLOOR: begin
					load_q <= (tmo[bidx_q[IW-1:0]] < MIN_LOAD) ? MIN_LOAD
						: tmo[bidx_q[IW-1:0]];
					llt_q <= cmd_q.now_ms;
					lv_q <= 1'b1;
				end
				ST_SVC_BIT: begin
					scan_q <= '0;
					if (!fired_q[bit_q] && 32'(bit_q) != EVENT_BITS - 1)
						bit_q <= bit_q + 5'd1;
				end
				ST_SVC_FIND: begin
					if (scan_in && scan_ev == bit_q) begin
						if (out_free) begin
							pos_q <= scan_q;
							fired_q[bit_q] <= 1'b0;
						end
					end else if (scan_in) scan_q <= scan_q + SW'(1);
					else begin
						fired_q[bit_q] <= 1'b0;
						if (32'(bit_q) != EVENT_BITS - 1) bit_q <= bit_q + 5'd1;
					end
				end
				ST_SVC_RM: begin
					count_q <= count_q - SW'(1);
					// this entry's result waits until it is known whether it is last
					svc_n_q <= 1'b1;
					svc_pend_q <= bit_q;
					if (32'(bit_q) != EVENT_BITS - 1) bit_q <= bit_q + 5'd1;
				end
				ST_QRY_FIND: begin
					if (scan_in && ev_ok && scan_ev == cmd_q.event_index) found_q <= 1'b1;
					else if (scan_in) scan_q <= scan_q + SW'(1);
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/motmr_cell.sv
`default_nettype none
module motmr_cell (
	input  wire logic                 clk,
	input  wire logic [5:0]           idx,
	input  wire motmr_pkg::cell_ctl_t ctl,
	input  wire logic [31:0]          right_tmo,
	input  wire logic [4:0]           right_ev,
	input  wire logic [31:0]          cur_load,
	output logic [31:0]               tmo_q,
	output logic [4:0]                ev_q,
	output logic                      hit_zero
);
	import motmr_pkg::*;

	logic        act;
	logic [31:0] sub_res;
	logic [31:0] exp_res;

	assign act     = idx < ctl.lim;
	assign sub_res = (tmo_q > ctl.sub_val) ? tmo_q - ctl.sub_val : '0;
	assign exp_res = (tmo_q > cur_load) ? tmo_q - cur_load : '0;
	// entry nonzero before the expire and zero after
	assign hit_zero = act && (tmo_q != '0) && (exp_res == '0);

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_SUB: if (act) tmo_q <= sub_res;
			OP_EXPIRE: if (act && tmo_q != '0) tmo_q <= exp_res;
			OP_REMOVE: if (idx >= ctl.pos) begin
				tmo_q <= right_tmo;
				ev_q  <= right_ev;
			end
			OP_APPEND: if (idx == ctl.pos) begin
				tmo_q <= ctl.new_tmo;
				ev_q  <= ctl.new_ev;
			end
			OP_FLOOR: if (idx == ctl.pos && tmo_q < MIN_LOAD) tmo_q <= MIN_LOAD;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/motmr_checker.sv
`default_nettype none
module motmr_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire motmr_pkg::out_item_t out_data
);
	import motmr_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	// a presented result carries known fields
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(out_data))
		else $error("unknown result fields");

	// a reload never loads less than the minimum
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.load_valid |-> out_data.load_value >= MIN_LOAD)
		else $error("reload below minimum");

	// acceptance makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("not busy after accept");
endmodule

bind multiplexed_oneshot_timer_table motmr_checker u_motmr_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
